// ===== hdl/cppt_pkg.sv =====
// ----------------------------------------------------------------------------
// Control point pick table package
// Codes, field widths and reset values shared by the table core, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package cppt_pkg;

    localparam int POS_W    = 12;
    localparam int NDC_W    = 16;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_ADD    = 2'd0;
    localparam mode_t MODE_SELECT = 2'd1;
    localparam mode_t MODE_MOVE   = 2'd2;
    localparam mode_t MODE_CLEAR  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_NOSEL = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_PICK_RADIUS   = 2'd0;
    localparam cfg_idx_t REG_SCREEN_WIDTH  = 2'd1;
    localparam cfg_idx_t REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [15:0] THR2_RESET   = 16'd9;
    localparam logic [11:0] WIDTH_RESET  = 12'd1024;
    localparam logic [11:0] HEIGHT_RESET = 12'd768;

endpackage

// ===== hdl/cppt_if.sv =====
// ----------------------------------------------------------------------------
// Control point pick table channels
// Valid/ready channels for pointer events, results and register writes.
// ----------------------------------------------------------------------------
interface pick_evt_if;
    logic                       valid;
    logic                       ready;
    cppt_pkg::mode_t            mode;
    logic [cppt_pkg::POS_W-1:0] pos_x;
    logic [cppt_pkg::POS_W-1:0] pos_y;

    modport source (output valid, output mode, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input mode, input pos_x, input pos_y, output ready);
endinterface

interface pick_res_if;
    logic                                valid;
    logic                                ready;
    cppt_pkg::status_t                   status;
    logic                                hit;
    logic [cppt_pkg::INDEX_W-1:0]        point_index;
    logic signed [cppt_pkg::NDC_W-1:0]   ndc_x;
    logic signed [cppt_pkg::NDC_W-1:0]   ndc_y;
    logic [cppt_pkg::COUNT_W-1:0]        point_count;

    modport source (output valid, output status, output hit, output point_index,
                    output ndc_x, output ndc_y, output point_count, input ready);
    modport sink   (input valid, input status, input hit, input point_index,
                    input ndc_x, input ndc_y, input point_count, output ready);
endinterface

interface pick_cfg_if;
    logic                            valid;
    logic                            ready;
    cppt_pkg::cfg_idx_t              index;
    logic [cppt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cppt_ram.sv =====
// ----------------------------------------------------------------------------
// Control point pick table RAM
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module cppt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/control_point_pick_table_core.sv =====
// ----------------------------------------------------------------------------
// Control point pick table core
// Stores pointer control points; adds, picks, moves and clears them, and
// returns normalized device coordinates through a shared iterative divider.
// ----------------------------------------------------------------------------
//  channel  role    words                                      handshake
//  evt      sink    mode, pos_x, pos_y                         valid/ready
//  res      source  status, hit, point_index, ndc_x, ndc_y,    valid/ready
//                   point_count
//  cfg      sink    index, data (register write)               valid/ready
//
//  Add and move run the one-bit-per-cycle divider once for x and once for y.
//  Select reads the stored points in order, one table read per cycle, and stops at the first hit.
//  Clear, full add and move with nothing selected go straight to the output.
//  Reset clears count and selection at once; table contents need no clearing.
//  A finished word waits in the output register; evt is ready again meanwhile.
// ----------------------------------------------------------------------------
module control_point_pick_table_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    pick_evt_if.sink    evt,
    pick_res_if.source  res,
    pick_cfg_if.sink    cfg
);

    import cppt_pkg::*;

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNW  = $clog2(MAX_POINTS + 1);
    localparam int CW   = COORD_BITS;
    localparam int KB   = (CW < POS_W) ? CW : POS_W;
    localparam int DW   = CW + 16;
    localparam int DCW  = $clog2(DW);
    localparam int SQW  = 2 * CW;
    localparam int SUMW = SQW + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DIVX = 5'b00100,
        S_DIVY = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    function automatic logic signed [NDC_W-1:0] sat_x(input logic [DW-1:0] q);
        logic big;
        big = |q[DW-1:16];
        sat_x = big ? 16'sh7FFF : {~q[15], q[14:0]};
    endfunction

    function automatic logic signed [NDC_W-1:0] sat_y(input logic [DW-1:0] q);
        logic big;
        big = |q[DW-1:16];
        if (q == '0)
        begin
            sat_y = 16'sh7FFF;
        end
        else if (big)
        begin
            sat_y = 16'sh8000;
        end
        else
        begin
            sat_y = 16'(16'h8000 - q[15:0]);
        end
    endfunction

    state_t state_reg, state_next;

    logic [CNW-1:0]  count_reg, count_next;
    logic            sel_valid_reg, sel_valid_next;
    logic [IW-1:0]   sel_slot_reg, sel_slot_next;
    logic [15:0]     thr2_reg, thr2_next;
    logic [11:0]     width_reg, width_next;
    logic [11:0]     height_reg, height_next;
    logic [CNW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic            s1_valid_reg, s1_valid_next;
    logic            s2_valid_reg, s2_valid_next;
    logic            s3_valid_reg, s3_valid_next;
    logic            o_valid_reg, o_valid_next;

    logic [CW-1:0]   x_reg, x_next;
    logic [CW-1:0]   y_reg, y_next;
    logic [IW-1:0]   s1_idx_reg, s1_idx_next;
    logic [IW-1:0]   s2_idx_reg, s2_idx_next;
    logic [IW-1:0]   s3_idx_reg, s3_idx_next;
    logic [CW-1:0]   s2_dx_reg, s2_dx_next;
    logic [CW-1:0]   s2_dy_reg, s2_dy_next;
    logic [SQW-1:0]  s3_sqx_reg, s3_sqx_next;
    logic [SQW-1:0]  s3_sqy_reg, s3_sqy_next;
    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [11:0]     rem_reg, rem_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;

    status_t                w_status_reg, w_status_next;
    logic                   w_hit_reg, w_hit_next;
    logic [IW-1:0]          w_index_reg, w_index_next;
    logic signed [NDC_W-1:0] w_ndc_x_reg, w_ndc_x_next;
    logic signed [NDC_W-1:0] w_ndc_y_reg, w_ndc_y_next;

    status_t                o_status_reg, o_status_next;
    logic                   o_hit_reg, o_hit_next;
    logic [INDEX_W-1:0]     o_index_reg, o_index_next;
    logic signed [NDC_W-1:0] o_ndc_x_reg, o_ndc_x_next;
    logic signed [NDC_W-1:0] o_ndc_y_reg, o_ndc_y_next;
    logic [COUNT_W-1:0]     o_count_reg, o_count_next;

    logic             accept;
    logic             full;
    logic [CW-1:0]    evt_x;
    logic [CW-1:0]    evt_y;
    logic [11:0]      wd;
    logic [11:0]      hd;
    logic [11:0]      d_cur;
    logic [12:0]      rem_sh;
    logic             ge;
    logic [DW-1:0]    q_next;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [2*CW-1:0]  ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [2*CW-1:0]  ram_rdata;
    logic [CW-1:0]    rd_x;
    logic [CW-1:0]    rd_y;
    logic             issue;
    logic             s3_hit;
    logic [15:0]      radius_ext;

    assign evt_x     = CW'(evt.pos_x[KB-1:0]);
    assign evt_y     = CW'(evt.pos_y[KB-1:0]);
    assign evt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = evt.valid && evt.ready;
    assign full      = (count_reg == CNW'(MAX_POINTS));
    assign wd        = (width_reg == 12'd0) ? 12'd1 : width_reg;
    assign hd        = (height_reg == 12'd0) ? 12'd1 : height_reg;
    assign d_cur     = (state_reg == S_DIVY) ? hd : wd;
    assign rem_sh    = {rem_reg, dvd_reg[DW-1]};
    assign ge        = (rem_sh >= {1'b0, d_cur});
    assign q_next    = {dvd_reg[DW-2:0], ge};
    assign rd_x      = ram_rdata[CW-1:0];
    assign rd_y      = ram_rdata[2*CW-1:CW];
    assign ram_raddr = rd_ptr_reg[IW-1:0];
    assign ram_wdata = {evt_y, evt_x};
    assign issue     = (rd_ptr_reg < count_reg);
    assign s3_hit    = s3_valid_reg &&
                       ((SUMW'(s3_sqx_reg) + SUMW'(s3_sqy_reg)) <= SUMW'(thr2_reg));
    assign radius_ext = {8'd0, cfg.data[7:0]};

    assign res.valid       = o_valid_reg;
    assign res.status      = o_status_reg;
    assign res.hit         = o_hit_reg;
    assign res.point_index = o_index_reg;
    assign res.ndc_x       = o_ndc_x_reg;
    assign res.ndc_y       = o_ndc_y_reg;
    assign res.point_count = o_count_reg;

    cppt_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_cppt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        thr2_next   = thr2_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_PICK_RADIUS:   thr2_next   = radius_ext * radius_ext;
                REG_SCREEN_WIDTH:  width_next  = cfg.data;
                REG_SCREEN_HEIGHT: height_next = cfg.data;
                default:           thr2_next   = thr2_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sel_valid_next = sel_valid_reg;
        sel_slot_next  = sel_slot_reg;
        rd_ptr_next    = rd_ptr_reg;
        s1_valid_next  = 1'b0;
        s2_valid_next  = 1'b0;
        s3_valid_next  = 1'b0;
        o_valid_next   = o_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        s1_idx_next    = rd_ptr_reg[IW-1:0];
        s2_idx_next    = s1_idx_reg;
        s3_idx_next    = s2_idx_reg;
        s2_dx_next     = (x_reg >= rd_x) ? (x_reg - rd_x) : (rd_x - x_reg);
        s2_dy_next     = (y_reg >= rd_y) ? (y_reg - rd_y) : (rd_y - y_reg);
        s3_sqx_next    = SQW'(s2_dx_reg) * SQW'(s2_dx_reg);
        s3_sqy_next    = SQW'(s2_dy_reg) * SQW'(s2_dy_reg);
        dvd_next       = q_next;
        rem_next       = ge ? 12'(rem_sh - {1'b0, d_cur}) : rem_sh[11:0];
        div_cnt_next   = div_cnt_reg + DCW'(1);
        w_status_next  = w_status_reg;
        w_hit_next     = w_hit_reg;
        w_index_next   = w_index_reg;
        w_ndc_x_next   = w_ndc_x_reg;
        w_ndc_y_next   = w_ndc_y_reg;
        o_status_next  = o_status_reg;
        o_hit_next     = o_hit_reg;
        o_index_next   = o_index_reg;
        o_ndc_x_next   = o_ndc_x_reg;
        o_ndc_y_next   = o_ndc_y_reg;
        o_count_next   = o_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IW-1:0];

        if (o_valid_reg && res.ready)
        begin
            o_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next        = evt_x;
                    y_next        = evt_y;
                    w_status_next = STATUS_OK;
                    w_hit_next    = 1'b0;
                    w_index_next  = '0;
                    w_ndc_x_next  = '0;
                    w_ndc_y_next  = '0;
                    dvd_next      = {evt_x, 16'(wd >> 1)};
                    rem_next      = '0;
                    div_cnt_next  = '0;
                    case (evt.mode)
                        MODE_ADD:
                        begin
                            if (full)
                            begin
                                w_status_next = STATUS_FULL;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                w_index_next = count_reg[IW-1:0];
                                count_next   = count_reg + CNW'(1);
                                state_next   = S_DIVX;
                            end
                        end
                        MODE_SELECT:
                        begin
                            sel_valid_next = 1'b0;
                            sel_slot_next  = '0;
                            rd_ptr_next    = '0;
                            state_next     = S_SCAN;
                        end
                        MODE_MOVE:
                        begin
                            if (!sel_valid_reg || (CNW'(sel_slot_reg) >= count_reg))
                            begin
                                w_status_next = STATUS_NOSEL;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = sel_slot_reg;
                                w_index_next = sel_slot_reg;
                                state_next   = S_DIVX;
                            end
                        end
                        default:
                        begin
                            count_next     = '0;
                            sel_valid_next = 1'b0;
                            sel_slot_next  = '0;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next   = rd_ptr_reg + CNW'(1);
                    s1_valid_next = 1'b1;
                end
                s2_valid_next = s1_valid_reg;
                s3_valid_next = s2_valid_reg;
                if (s3_hit)
                begin
                    sel_valid_next = 1'b1;
                    sel_slot_next  = s3_idx_reg;
                    w_hit_next     = 1'b1;
                    w_index_next   = s3_idx_reg;
                    s1_valid_next  = 1'b0;
                    s2_valid_next  = 1'b0;
                    s3_valid_next  = 1'b0;
                    state_next     = S_OUT;
                end
                else if (!issue && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_DIVX:
            begin
                if (div_cnt_reg == DCW'(DW - 1))
                begin
                    w_ndc_x_next = sat_x(q_next);
                    dvd_next     = {y_reg, 16'(hd >> 1)};
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_cnt_reg == DCW'(DW - 1))
                begin
                    w_ndc_y_next = sat_y(q_next);
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!o_valid_reg || res.ready)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = w_status_reg;
                    o_hit_next    = w_hit_reg;
                    o_index_next  = INDEX_W'(w_index_reg);
                    o_ndc_x_next  = w_ndc_x_reg;
                    o_ndc_y_next  = w_ndc_y_reg;
                    o_count_next  = COUNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sel_valid_reg <= 1'b0;
            sel_slot_reg  <= '0;
            thr2_reg      <= THR2_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sel_valid_reg <= sel_valid_next;
            sel_slot_reg  <= sel_slot_next;
            thr2_reg      <= thr2_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            o_valid_reg   <= o_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        s3_idx_reg   <= s3_idx_next;
        s2_dx_reg    <= s2_dx_next;
        s2_dy_reg    <= s2_dy_next;
        s3_sqx_reg   <= s3_sqx_next;
        s3_sqy_reg   <= s3_sqy_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        w_status_reg <= w_status_next;
        w_hit_reg    <= w_hit_next;
        w_index_reg  <= w_index_next;
        w_ndc_x_reg  <= w_ndc_x_next;
        w_ndc_y_reg  <= w_ndc_y_next;
        o_status_reg <= o_status_next;
        o_hit_reg    <= o_hit_next;
        o_index_reg  <= o_index_next;
        o_ndc_x_reg  <= o_ndc_x_next;
        o_ndc_y_reg  <= o_ndc_y_next;
        o_count_reg  <= o_count_next;
    end

endmodule

// ===== hdl/cppt_checker.sv =====
// ----------------------------------------------------------------------------
// Control point pick table checker
// Port-level assertions on the table core, bound to every instance.
// ----------------------------------------------------------------------------
module cppt_checker #(
    parameter int MAX_POINTS = 64
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              evt_valid,
    input logic                              evt_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input cppt_pkg::status_t                 res_status,
    input logic                              res_hit,
    input logic [cppt_pkg::INDEX_W-1:0]      res_point_index,
    input logic signed [cppt_pkg::NDC_W-1:0] res_ndc_x,
    input logic signed [cppt_pkg::NDC_W-1:0] res_ndc_y,
    input logic [cppt_pkg::COUNT_W-1:0]      res_point_count
);

    import cppt_pkg::*;

    // hold a stalled word: valid, status, point count and ndc_x stay
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) &&
                                    $stable(res_point_count) && $stable(res_ndc_x))
    else $error("result word changed while stalled");

    // busy after every accepted event
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
    else $error("event accepted while previous one in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_hit |-> res_status == STATUS_OK && res_ndc_x == 16'sd0 &&
                                 res_ndc_y == 16'sd0)
    else $error("hit word carries status or coordinates");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_FULL |->
            res_point_count == COUNT_W'(MAX_POINTS) && res_point_index == '0 && !res_hit)
    else $error("full status without a full table");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STATUS_NOSEL |->
            res_point_index == '0 && res_ndc_x == 16'sd0 && res_ndc_y == 16'sd0)
    else $error("move without selection returned data");

endmodule

bind control_point_pick_table_core cppt_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_cppt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_valid       (evt.valid),
    .evt_ready       (evt.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_hit         (res.hit),
    .res_point_index (res.point_index),
    .res_ndc_x       (res.ndc_x),
    .res_ndc_y       (res.ndc_y),
    .res_point_count (res.point_count)
);
